// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside of reset
`define CHK_ASSERT(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// checked on every rising edge, reset included
`define CHK_ASSERT_NR(label, ck, prop, msg) \
  label: assert property (@(posedge ck) prop) else $error(msg);

`endif

// File: hw/rtl/acfp_pkg.sv
package acfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COORD_W = 14;
  localparam int unsigned ERR_W   = 15;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_DATA_W = 64;

  localparam logic [BYTE_W-1:0] CHAR_START = 8'h23;  // '#'
  localparam logic [BYTE_W-1:0] CHAR_SEP   = 8'h7C;  // '|'
  localparam logic [BYTE_W-1:0] CHAR_END   = 8'h24;  // '$'
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;  // '9'

  localparam logic [POS_W-1:0] POS_IDLE   = 4'd0;
  localparam logic [POS_W-1:0] POS_FIRST  = 4'd1;
  localparam logic [POS_W-1:0] POS_X_LAST = 4'd4;
  localparam logic [POS_W-1:0] POS_SEP    = 4'd5;
  localparam logic [POS_W-1:0] POS_Y_LAST = 4'd9;
  localparam logic [POS_W-1:0] POS_LAST   = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COORD = 2'd2;

  localparam logic [COORD_W-1:0] CENTER_X_RST  = 14'd224;
  localparam logic [COORD_W-1:0] CENTER_Y_RST  = 14'd224;
  localparam logic [COORD_W-1:0] MAX_COORD_RST = 14'd448;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [ERR_W-1:0]   x_error;
    logic [ERR_W-1:0]   y_error;
  } frame_res_t;

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

endpackage

// File: hw/rtl/acfp_frame.sv
`include "assert_macros.svh"

module acfp_frame (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [acfp_pkg::BYTE_W-1:0]     rx_byte,
  input  logic [acfp_pkg::COORD_W-1:0]    center_x,
  input  logic [acfp_pkg::COORD_W-1:0]    center_y,
  input  logic [acfp_pkg::COORD_W-1:0]    max_coord,
  output acfp_pkg::frame_res_t            res
);

  logic [acfp_pkg::POS_W-1:0]   pos, pos_next;
  logic [acfp_pkg::COORD_W-1:0] x_accum, x_accum_next;
  logic [acfp_pkg::COORD_W-1:0] y_accum, y_accum_next;
  logic                         format_ok, format_ok_next;

  logic                         digit;
  logic [acfp_pkg::COORD_W-1:0] digit_val;
  logic                         in_x, in_y;

  assign digit     = acfp_pkg::is_digit(rx_byte);
  assign digit_val = acfp_pkg::COORD_W'(rx_byte - acfp_pkg::CHAR_ZERO);
  assign in_x      = (pos >= acfp_pkg::POS_FIRST) && (pos <= acfp_pkg::POS_X_LAST);
  assign in_y      = (pos > acfp_pkg::POS_SEP) && (pos <= acfp_pkg::POS_Y_LAST);

  always_comb begin
    pos_next       = pos;
    x_accum_next   = x_accum;
    y_accum_next   = y_accum;
    format_ok_next = format_ok;
    res            = '0;
    if (step) begin
      if (rx_byte == acfp_pkg::CHAR_START) begin
        pos_next       = acfp_pkg::POS_FIRST;
        x_accum_next   = '0;
        y_accum_next   = '0;
        format_ok_next = 1'b1;
      end else if (pos == acfp_pkg::POS_IDLE || pos > acfp_pkg::POS_LAST) begin
        pos_next = acfp_pkg::POS_IDLE;
      end else begin
        // acc * 10 + digit, wrapping at 14 bits
        if (in_x) begin
          if (digit) begin
            x_accum_next = {x_accum[acfp_pkg::COORD_W-4:0], 3'b000}
                         + {x_accum[acfp_pkg::COORD_W-2:0], 1'b0} + digit_val;
          end else begin
            format_ok_next = 1'b0;
          end
        end else if (pos == acfp_pkg::POS_SEP) begin
          if (rx_byte != acfp_pkg::CHAR_SEP) format_ok_next = 1'b0;
        end else if (in_y) begin
          if (digit) begin
            y_accum_next = {y_accum[acfp_pkg::COORD_W-4:0], 3'b000}
                         + {y_accum[acfp_pkg::COORD_W-2:0], 1'b0} + digit_val;
          end else begin
            format_ok_next = 1'b0;
          end
        end else if (rx_byte != acfp_pkg::CHAR_END) begin
          format_ok_next = 1'b0;
        end

        if (pos < acfp_pkg::POS_LAST) begin
          pos_next = pos + 1'b1;
        end else begin
          // both values are complete by the terminator slot
          pos_next    = acfp_pkg::POS_IDLE;
          res.valid   = format_ok_next && (x_accum <= max_coord) && (y_accum <= max_coord);
          res.x_coord = x_accum;
          res.y_coord = y_accum;
          res.x_error = {1'b0, x_accum} - {1'b0, center_x};
          res.y_error = {1'b0, y_accum} - {1'b0, center_y};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= acfp_pkg::POS_IDLE;
      x_accum   <= '0;
      y_accum   <= '0;
      format_ok <= 1'b1;
    end else begin
      pos       <= pos_next;
      x_accum   <= x_accum_next;
      y_accum   <= y_accum_next;
      format_ok <= format_ok_next;
    end
  end

  `CHK_ASSERT(a_pos_range, clk, rst, pos <= acfp_pkg::POS_LAST, "frame position out of range")
  `CHK_ASSERT(a_res_at_end, clk, rst, res.valid |-> (step && pos == acfp_pkg::POS_LAST), "result outside terminator slot")
  `CHK_ASSERT(a_res_in_range, clk, rst, res.valid |-> (res.x_coord <= max_coord && res.y_coord <= max_coord), "result above max_coord")

endmodule

// File: hw/rtl/ascii_coordinate_frame_parser_core.sv
// ascii coordinate frame parser
// s_* channel: one received byte per transfer. frames look like #dddd|dddd$;
// a '#' restarts a frame anywhere, bytes outside a frame are ignored.
// m_* channel: one transfer per good frame, with x, y and their offsets from
// the configured centre; malformed frames or values above max_coord are dropped.
// cfg_we/cfg_index/cfg_data write center_x (0), center_y (1), max_coord (2);
// index 3 is ignored. write only while the block is idle.
// output: the terminator byte passes through the input register, then the
// result register, whose valid bit drives m_tvalid.
// throughput: one byte per cycle unless the output stalls; the per-byte
// accumulate sits between the input register and the frame state, the range
// check and subtract between the stored accumulators and the result register.
// when m_tready is low with a result pending, the input register holds its
// byte and s_tready drops once it is full; nothing is lost.
// reset (rst, synchronous) closes any open frame, empties both registers and
// restores center 224/224 and max_coord 448.
`include "assert_macros.svh"

module ascii_coordinate_frame_parser_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [acfp_pkg::BYTE_W-1:0]          s_tdata,  // [7:0] rx_byte
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [13:0] x_coord, [27:14] y_coord, [42:28] x_error, [57:43] y_error, rest zero
  output logic [acfp_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                 cfg_we,
  input  logic [acfp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [acfp_pkg::COORD_W-1:0]         cfg_data
);

  logic [acfp_pkg::COORD_W-1:0] center_x, center_y, max_coord;
  logic                         in_valid;
  logic [acfp_pkg::BYTE_W-1:0]  in_byte;
  logic                         advance;
  logic                         step;
  acfp_pkg::frame_res_t         res;

  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x  <= acfp_pkg::CENTER_X_RST;
      center_y  <= acfp_pkg::CENTER_Y_RST;
      max_coord <= acfp_pkg::MAX_COORD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        acfp_pkg::CFG_CENTER_X:  center_x  <= cfg_data;
        acfp_pkg::CFG_CENTER_Y:  center_y  <= cfg_data;
        acfp_pkg::CFG_MAX_COORD: max_coord <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  acfp_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (in_byte),
    .center_x  (center_x),
    .center_y  (center_y),
    .max_coord (max_coord),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tdata <= {{(acfp_pkg::OUT_DATA_W - 2*acfp_pkg::COORD_W - 2*acfp_pkg::ERR_W){1'b0}},
                  res.y_error, res.x_error, res.y_coord, res.x_coord};
    end
  end

  `CHK_ASSERT(a_out_from_input, clk, rst, $rose(m_tvalid) |-> $past(in_valid), "result without a buffered byte")
  `CHK_ASSERT(a_in_hold, clk, rst, (in_valid && !advance) |=> (in_valid && $stable(in_byte)), "buffered byte lost under stall")
  `CHK_ASSERT_NR(a_reset_empty, clk, rst |=> (!m_tvalid && !in_valid), "registers not empty after reset")

endmodule

// File: sim/ascii_coordinate_frame_parser_core_tb.sv
module ascii_coordinate_frame_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import acfp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 300;
  localparam int MAX_VALUE = 9999;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ERR_W-1:0]   ex;
    logic [ERR_W-1:0]   ey;
  } coord_result_t;

  typedef enum int {
    FK_GOOD,
    FK_OVER,
    FK_BAD_SEP,
    FK_BAD_END,
    FK_BAD_DIGIT,
    FK_CUT,
    FK_NOISE
  } frame_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;     // [7:0] rx_byte
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [13:0] x_coord, [27:14] y_coord, [42:28] x_error, [57:43] y_error
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COORD_W-1:0]    cfg_data = '0;

  ascii_coordinate_frame_parser_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // parser copy: register settings and frame state
  logic [COORD_W-1:0] ctr_x = CENTER_X_RST;
  logic [COORD_W-1:0] ctr_y = CENTER_Y_RST;
  logic [COORD_W-1:0] coord_lim = MAX_COORD_RST;
  logic [POS_W-1:0]   frame_pos = POS_IDLE;
  logic [COORD_W-1:0] acc_x = '0;
  logic [COORD_W-1:0] acc_y = '0;
  logic               frame_ok = 1'b1;

  logic [BYTE_W-1:0]  rx_bytes_q[$];
  coord_result_t      coords_due_q[$];
  int                 bytes_pushed = 0;
  int                 mismatches = 0;
  int                 quiet_cycles = 0;

  bit                 in_xfer = 1'b0;
  int                 max_gap = 0;
  int                 max_burst = 1;
  int                 stall_pct = 0;
  int                 gap_left = 0;
  int                 burst_left = 0;
  bit                 hold_req = 1'b0;
  int                 hold_left = 0;

  coord_result_t      got_res;
  coord_result_t      due_res;

  function automatic logic [COORD_W-1:0] add_digit(logic [COORD_W-1:0] acc,
                                                   logic [BYTE_W-1:0] b);
    if (b < CHAR_ZERO || b > CHAR_NINE) begin
      frame_ok = 1'b0;
      return acc;
    end
    return COORD_W'(acc * 10 + (b - CHAR_ZERO));
  endfunction

  // advances the frame state by one byte; returns 1 when a result is due
  function automatic bit decode_byte(logic [BYTE_W-1:0] b, output coord_result_t r);
    logic [POS_W-1:0] p;
    p = frame_pos;
    r = '0;
    if (b == CHAR_START) begin
      frame_pos = POS_FIRST;
      acc_x = '0;
      acc_y = '0;
      frame_ok = 1'b1;
      return 1'b0;
    end
    if (p == POS_IDLE || p > POS_LAST) begin
      frame_pos = POS_IDLE;
      return 1'b0;
    end
    if (p <= POS_X_LAST) begin
      acc_x = add_digit(acc_x, b);
    end else if (p == POS_SEP) begin
      if (b != CHAR_SEP) frame_ok = 1'b0;
    end else if (p <= POS_Y_LAST) begin
      acc_y = add_digit(acc_y, b);
    end else if (b != CHAR_END) begin
      frame_ok = 1'b0;
    end
    if (p < POS_LAST) begin
      frame_pos = p + 1'b1;
      return 1'b0;
    end
    frame_pos = POS_IDLE;
    if (!frame_ok || acc_x > coord_lim || acc_y > coord_lim) return 1'b0;
    r.x = acc_x;
    r.y = acc_y;
    r.ex = ERR_W'({1'b0, acc_x} - {1'b0, ctr_x});
    r.ey = ERR_W'({1'b0, acc_y} - {1'b0, ctr_y});
    return 1'b1;
  endfunction

  function automatic void check_field(string name, int want, int seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endfunction

  // sender: bursts of random length, random gaps, valid held until the transfer
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_xfer) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (rx_bytes_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata <= rx_bytes_q[0];
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, max_burst);
          gap_left = $urandom_range(0, max_gap);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_xfer = 1'b0;
    end else begin
      in_xfer = s_tvalid && s_tready;
      if (in_xfer) begin
        void'(rx_bytes_q.pop_front());
        if (decode_byte(s_tdata, due_res)) coords_due_q.push_back(due_res);
      end
      if (m_tvalid && m_tready) begin
        got_res.x = m_tdata[COORD_W-1:0];
        got_res.y = m_tdata[2*COORD_W-1:COORD_W];
        got_res.ex = m_tdata[2*COORD_W+ERR_W-1:2*COORD_W];
        got_res.ey = m_tdata[2*COORD_W+2*ERR_W-1:2*COORD_W+ERR_W];
        if (coords_due_q.size() == 0) begin
          $error("result with no frame pending: x %0d y %0d", got_res.x, got_res.y);
          mismatches++;
        end else begin
          due_res = coords_due_q.pop_front();
          check_field("x_coord", int'(due_res.x), int'(got_res.x));
          check_field("y_coord", int'(due_res.y), int'(got_res.y));
          check_field("x_error", int'($signed(due_res.ex)), int'($signed(got_res.ex)));
          check_field("y_error", int'($signed(due_res.ey)), int'($signed(got_res.ey)));
        end
      end
      if (in_xfer || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ascii_coordinate_frame_parser_core_tb: errors");
        $finish;
      end
    end
  end

  task automatic push_byte(logic [BYTE_W-1:0] b);
    rx_bytes_q.push_back(b);
    bytes_pushed++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CENTER_X:  ctr_x = val;
      CFG_CENTER_Y:  ctr_y = val;
      CFG_MAX_COORD: coord_lim = val;
      default:       ;
    endcase
  endtask

  task automatic set_regs(int cx, int cy, int lim);
    write_reg(CFG_CENTER_X, COORD_W'(cx));
    write_reg(CFG_CENTER_Y, COORD_W'(cy));
    write_reg(CFG_MAX_COORD, COORD_W'(lim));
  endtask

  // waits until every byte is taken and every result is back, then lets the pipe empty
  task automatic settle();
    while (rx_bytes_q.size() != 0 || coords_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_coord(bit over);
    int top;
    top = (coord_lim > MAX_VALUE) ? MAX_VALUE : int'(coord_lim);
    if (over && top < MAX_VALUE) return $urandom_range(top + 1, MAX_VALUE);
    case ($urandom_range(0, 5))
      0:       return top;
      1:       return 0;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  // random byte other than a frame start and 'avoid', optionally no digit either
  function automatic logic [BYTE_W-1:0] odd_byte(logic [BYTE_W-1:0] avoid, bit no_digit);
    logic [BYTE_W-1:0] b;
    do begin
      b = BYTE_W'($urandom_range(0, 255));
    end while (b == avoid || b == CHAR_START ||
               (no_digit && b >= CHAR_ZERO && b <= CHAR_NINE));
    return b;
  endfunction

  task automatic push_random_frame();
    int sel;
    int xv;
    int yv;
    int place;
    int len;
    int slot;
    frame_kind_t kind;
    logic [BYTE_W-1:0] f [11];
    sel = $urandom_range(0, 99);
    if (sel < 55)      kind = FK_GOOD;
    else if (sel < 65) kind = FK_OVER;
    else if (sel < 72) kind = FK_BAD_SEP;
    else if (sel < 79) kind = FK_BAD_END;
    else if (sel < 86) kind = FK_BAD_DIGIT;
    else if (sel < 93) kind = FK_CUT;
    else               kind = FK_NOISE;
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom_range(0, 255)));
      return;
    end
    sel = $urandom_range(0, 2);
    xv = pick_coord(kind == FK_OVER && sel != 1);
    yv = pick_coord(kind == FK_OVER && sel != 0);
    f[0] = CHAR_START;
    f[5] = CHAR_SEP;
    f[10] = CHAR_END;
    place = 1000;
    for (int i = 0; i < 4; i++) begin
      f[1 + i] = CHAR_ZERO + BYTE_W'((xv / place) % 10);
      f[6 + i] = CHAR_ZERO + BYTE_W'((yv / place) % 10);
      place = place / 10;
    end
    len = 11;
    case (kind)
      FK_BAD_SEP: f[5] = odd_byte(CHAR_SEP, 1'b0);
      FK_BAD_END: f[10] = odd_byte(CHAR_END, 1'b0);
      FK_BAD_DIGIT: begin
        slot = $urandom_range(1, 8);
        if (slot > 4) slot++;
        f[slot] = odd_byte(CHAR_START, 1'b1);
      end
      FK_CUT: len = $urandom_range(1, 10);
      default: ;
    endcase
    for (int i = 0; i < len; i++) push_byte(f[i]);
  endtask

  task automatic run_phase(int gap, int burst, int stall, bit hold);
    int start;
    @(posedge clk);
    max_gap = gap;
    max_burst = burst;
    stall_pct = stall;
    start = bytes_pushed;
    while (bytes_pushed - start < PHASE_BYTES) push_random_frame();
    if (hold) hold_req = 1'b1;
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: bytes outside a frame, boundary value, restart inside a frame
    max_gap = 2;
    max_burst = 4;
    stall_pct = 20;
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("#0448|0000$");
    push_text("#12#0000|0448$");
    settle();

    set_regs(0, 0, MAX_VALUE);
    run_phase(0, 1, 0, 1'b0);

    set_regs(MAX_VALUE, MAX_VALUE, MAX_VALUE);
    run_phase(3, 6, 30, 1'b1);

    // all-ones registers, then a write to the unused index that must change nothing
    set_regs(16383, 16383, 16383);
    write_reg(CFG_UNUSED, '1);
    run_phase(8, 3, 60, 1'b0);

    set_regs(5000, 1234, 0);
    run_phase(2, 8, 10, 1'b0);

    set_regs($urandom_range(0, 16383), $urandom_range(0, 16383),
             $urandom_range(0, MAX_VALUE));
    run_phase(5, 5, 50, 1'b0);

    set_regs(int'(CENTER_X_RST), int'(CENTER_Y_RST), int'(MAX_COORD_RST));
    run_phase(1, 12, 80, 1'b0);

    if (mismatches == 0) begin
      $display("ascii_coordinate_frame_parser_core_tb: clean");
    end else begin
      $display("ascii_coordinate_frame_parser_core_tb: errors");
    end
    $finish;
  end

endmodule
